// ===== rtl/core/crc64rbe_pkg.sv =====
// ----------------------------------------------------------------------------
// crc64rbe_pkg
// Shared types and constants for the reflected CRC-64 byte engine.
// ----------------------------------------------------------------------------
package crc64rbe_pkg;

   localparam int unsigned CRC_WIDTH      = 64;
   localparam int unsigned BITS_PER_BYTE  = 8;
   localparam int unsigned CSR_ADDR_WIDTH = 4;
   localparam int unsigned CSR_DATA_WIDTH = 64;

   typedef logic [CRC_WIDTH-1:0]      crc_type;
   typedef logic [BITS_PER_BYTE-1:0]  byte_type;
   typedef logic [CSR_ADDR_WIDTH-1:0] csr_addr_type;
   typedef logic [CSR_DATA_WIDTH-1:0] csr_data_type;

   // Reflected ECMA-182 generator polynomial.
   localparam crc_type POLY_RESET = 64'hC96C_5795_D787_0F42;

   // Register map: the only register sits at byte address zero.
   localparam csr_addr_type ADDR_POLYNOMIAL = 4'h0;

endpackage

// ===== rtl/core/crc64rbe_fold.sv =====
// ----------------------------------------------------------------------------
// crc64rbe_fold
// Folds one byte into a reflected CRC with eight shift-and-XOR steps.
// ----------------------------------------------------------------------------
module crc64rbe_fold (
   input  crc64rbe_pkg::crc_type  crc_in,
   input  crc64rbe_pkg::byte_type data_in,
   input  crc64rbe_pkg::crc_type  poly,
   output crc64rbe_pkg::crc_type  crc_out
);

   always_comb begin
      crc64rbe_pkg::crc_type acc;
      acc = crc_in ^ {{(crc64rbe_pkg::CRC_WIDTH - crc64rbe_pkg::BITS_PER_BYTE){1'b0}}, data_in};
      for (int k = 0; k < crc64rbe_pkg::BITS_PER_BYTE; k++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ poly;
         end else begin
            acc = acc >> 1;
         end
      end
      crc_out = acc;
   end

endmodule

// ===== rtl/core/crc64rbe_csr.sv =====
// ----------------------------------------------------------------------------
// crc64rbe_csr
// APB-style register block holding the reflected polynomial.
// ----------------------------------------------------------------------------
module crc64rbe_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  crc64rbe_pkg::csr_addr_type csr_paddr,
   input  crc64rbe_pkg::csr_data_type csr_pwdata,
   output crc64rbe_pkg::csr_data_type csr_prdata,
   output logic                       csr_pready,
   output crc64rbe_pkg::crc_type      poly
);

   crc64rbe_pkg::crc_type poly_ff;
   crc64rbe_pkg::crc_type poly_in;
   logic                  poly_write;

   assign csr_pready = 1'b1;
   assign poly_write = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr == crc64rbe_pkg::ADDR_POLYNOMIAL);

   always_comb begin
      poly_in = poly_write ? csr_pwdata : poly_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= crc64rbe_pkg::POLY_RESET;
      end else begin
         poly_ff <= poly_in;
      end
   end

   always_comb begin
      unique case (csr_paddr)
         crc64rbe_pkg::ADDR_POLYNOMIAL: csr_prdata = poly_ff;
         default:                       csr_prdata = '0;
      endcase
   end

   assign poly = poly_ff;

endmodule

// ===== rtl/core/crc64_reflected_byte_engine_core.sv =====
// ----------------------------------------------------------------------------
// crc64_reflected_byte_engine_core
// Streaming reflected CRC-64 engine, one message byte per beat.
// ----------------------------------------------------------------------------
// The engine takes one message byte per beat and sustains one byte per clock
// cycle unless a last byte is blocked. A beat is first captured in an input
// register; from there the byte is folded, least significant bit first, into
// the running CRC by an eight-step shift-and-XOR network, and that network
// between the input register and the result register is what sets the cycle
// time. A message's finished CRC is loaded into the result register as its
// last byte is folded. req_tuser marks the first byte of a message and
// clears the running CRC before that byte; req_tlast marks the final byte,
// after which the CRC is emitted without any final inversion and the running
// value returns to zero. req_tready only drops while a finished CRC waits in
// the result register and the byte in the input register would produce
// another one. The reflected polynomial resets to the ECMA-182 value and is
// written through the register port at address zero; write it only while
// the engine is idle.
// ----------------------------------------------------------------------------
module crc64_reflected_byte_engine_core (
   input  logic                       clock,
   input  logic                       reset,
   // Input stream
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // [7:0] data_byte
   input  logic                       req_tuser,   // [0] first_byte
   input  logic                       req_tlast,   // last_byte
   // Result stream
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [63:0]                rsp_tdata,   // [63:0] crc_value
   // Register port
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  crc64rbe_pkg::csr_addr_type csr_paddr,
   input  crc64rbe_pkg::csr_data_type csr_pwdata,
   output crc64rbe_pkg::csr_data_type csr_prdata,
   output logic                       csr_pready
);

   // Input register: the byte waiting to be folded.
   logic                   s1_valid_ff,  s1_valid_in;
   crc64rbe_pkg::byte_type s1_data_ff;
   logic                   s1_first_ff;
   logic                   s1_last_ff;

   // Running CRC and result register.
   crc64rbe_pkg::crc_type  running_crc_ff, running_crc_in;
   logic                   rsp_valid_ff,   rsp_valid_in;
   crc64rbe_pkg::crc_type  rsp_data_ff,    rsp_data_in;

   crc64rbe_pkg::crc_type  poly;
   crc64rbe_pkg::crc_type  crc_start;
   crc64rbe_pkg::crc_type  crc_fold;
   logic                   s1_advance;
   logic                   req_accept;
   logic                   finish;

   crc64rbe_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .poly        (poly)
   );

   // A first byte starts from zero instead of the running value.
   assign crc_start = s1_first_ff ? '0 : running_crc_ff;

   crc64rbe_fold u_fold (
      .crc_in  (crc_start),
      .data_in (s1_data_ff),
      .poly    (poly),
      .crc_out (crc_fold)
   );

   // A byte that does not end a message always moves on; a last byte moves
   // on only when the result register is free or being emptied this cycle.
   assign s1_advance = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_tready);
   assign finish     = s1_advance && s1_last_ff;
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      // The running CRC goes back to zero once the last byte of a message is folded.
      if (s1_advance) begin
         running_crc_in = s1_last_ff ? '0 : crc_fold;
      end else begin
         running_crc_in = running_crc_ff;
      end

      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = crc_fold;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_tready;
         rsp_data_in  = rsp_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         running_crc_ff <= '0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         running_crc_ff <= running_crc_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff  <= req_tdata;
         s1_first_ff <= req_tuser;
         s1_last_ff  <= req_tlast;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // After reset the engine holds no byte, no result and a zero CRC.
   a_reset_clean: assert property (@(posedge clock)
      $past(reset) |-> (!s1_valid_ff && !rsp_valid_ff && running_crc_ff == '0))
      else $error("engine not clean after reset");

   // Folding a last byte loads a result and clears the running CRC.
   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      finish |=> (rsp_valid_ff && running_crc_ff == '0))
      else $error("last byte did not produce a result or clear the CRC");

   // Back-pressure only comes from a waiting result blocking a last byte.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && s1_last_ff && rsp_valid_ff && !rsp_tready))
      else $error("input stalled without a blocked result");

   // A byte without the last mark never creates a result.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && !finish) |=> !rsp_valid_ff)
      else $error("result appeared without a last byte");

   // A write to the polynomial register takes effect on the next cycle.
   a_poly_write: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite &&
       csr_paddr == crc64rbe_pkg::ADDR_POLYNOMIAL) |=> (poly == $past(csr_pwdata)))
      else $error("polynomial write lost");

endmodule

// ===== tb/crc64_stream_checker.sv =====
// ----------------------------------------------------------------------------
// crc64_stream_checker
// Watches the engine's channels, predicts each finished CRC and compares it.
// ----------------------------------------------------------------------------
module crc64_stream_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [7:0]                 req_tdata,    // [7:0] data_byte
   input  logic                       req_tuser,    // [0] first_byte
   input  logic                       req_tlast,    // last_byte
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [63:0]                rsp_tdata,    // [63:0] crc_value
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  crc64rbe_pkg::csr_addr_type csr_paddr,
   input  crc64rbe_pkg::csr_data_type csr_pwdata,
   input  logic                       csr_pready,
   output int                         fail_count,
   output int                         crc_pending
);

   crc64rbe_pkg::crc_type poly_shadow;
   crc64rbe_pkg::crc_type crc_accum;
   crc64rbe_pkg::crc_type finished_crc_q[$];

   // Folds one byte into the CRC, least significant bit first.
   function automatic crc64rbe_pkg::crc_type fold_crc_byte(
      crc64rbe_pkg::crc_type  crc,
      crc64rbe_pkg::byte_type data,
      crc64rbe_pkg::crc_type  poly
   );
      crc64rbe_pkg::crc_type acc;
      acc = crc ^ crc64rbe_pkg::crc_type'(data);
      for (int k = 0; k < crc64rbe_pkg::BITS_PER_BYTE; k++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ poly;
         end else begin
            acc = acc >> 1;
         end
      end
      return acc;
   endfunction

   always @(posedge clock) begin
      crc64rbe_pkg::crc_type next_crc;
      crc64rbe_pkg::crc_type want;
      if (reset) begin
         poly_shadow = crc64rbe_pkg::POLY_RESET;
         crc_accum   = '0;
         finished_crc_q.delete();
         fail_count  <= 0;
         crc_pending <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == crc64rbe_pkg::ADDR_POLYNOMIAL) begin
            poly_shadow = csr_pwdata;
         end

         if (rsp_tvalid && rsp_tready) begin
            if (finished_crc_q.size() == 0) begin
               $display("%0t: unexpected crc result, expected none, got %h",
                        $time, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = finished_crc_q.pop_front();
               if (rsp_tdata !== want) begin
                  $display("%0t: crc_value mismatch, expected %h, got %h",
                           $time, want, rsp_tdata);
                  fail_count <= fail_count + 1;
               end
            end
         end

         if (req_tvalid && req_tready) begin
            next_crc = fold_crc_byte(req_tuser ? crc64rbe_pkg::crc_type'(0) : crc_accum,
                                     req_tdata, poly_shadow);
            if (req_tlast) begin
               finished_crc_q.push_back(next_crc);
               crc_accum = '0;
            end else begin
               crc_accum = next_crc;
            end
         end

         crc_pending <= finished_crc_q.size();
      end
   end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the reflected CRC-64 byte engine.
// ----------------------------------------------------------------------------
// A directed part covers one-byte messages, a known ASCII message, messages
// that start without the first mark, restarts in the middle of a message,
// an unmapped register write, a polynomial change to all ones between bytes
// of an open message, and the all-zero polynomial. Random phases then
// stream mostly well-formed messages with random content and some noise,
// each phase under a new polynomial. The checker beside the engine predicts
// every finished CRC and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;

   // Generous bound on the whole run.
   localparam int CYCLE_LIMIT = 500000;
   // Cycles to let a byte in flight finish before touching the register.
   localparam int ENGINE_SETTLE = 8;
   localparam int PHASE_ITEMS = 150;
   localparam int PHASE_COUNT = 6;
   // Byte address of the first slot past the register map.
   localparam crc64rbe_pkg::csr_addr_type ADDR_UNMAPPED = 4'h8;

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [7:0]                 req_tdata;    // [7:0] data_byte
   logic                       req_tuser;    // [0] first_byte
   logic                       req_tlast;    // last_byte
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [63:0]                rsp_tdata;    // [63:0] crc_value
   logic                       csr_psel;
   logic                       csr_penable;
   logic                       csr_pwrite;
   crc64rbe_pkg::csr_addr_type csr_paddr;
   crc64rbe_pkg::csr_data_type csr_pwdata;
   crc64rbe_pkg::csr_data_type csr_prdata;
   logic                       csr_pready;

   int fail_count;
   int crc_pending;
   int cycle_count;
   // When cleared, neither side inserts idle cycles.
   bit idle_enable;
   // Bytes still to send in the current well-formed message.
   int msg_left;

   crc64_reflected_byte_engine_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   crc64_stream_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .crc_pending (crc_pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: ends the run if the traffic never drains.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // Result side back-pressure. Each cycle there is a small chance of a stall
   // burst, so stalls land on every phase of the engine's work.
   initial begin
      rsp_tready = 1'b1;
      forever begin
         @(negedge clock);
         if (idle_enable && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Sends one byte beat. Called and returns at a falling edge. The valid is
   // only dropped when an idle burst precedes the beat, so back-to-back beats
   // keep it high without a glitch.
   task automatic send_byte(input crc64rbe_pkg::byte_type data, input bit first,
                            input bit last);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= first;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Brings the engine to rest: no beat offered, every finished CRC received,
   // and enough extra cycles for a byte without the last mark to be folded.
   task automatic settle_engine();
      req_tvalid <= 1'b0;
      while (crc_pending != 0) @(negedge clock);
      repeat (ENGINE_SETTLE) @(negedge clock);
   endtask

   // Register write: setup cycle, then access cycle until pready.
   task automatic csr_write(input crc64rbe_pkg::csr_addr_type addr,
                            input crc64rbe_pkg::csr_data_type data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Random traffic: mostly well-formed messages of random length and
   // content, with the occasional noise beat whose marks are random.
   task automatic run_traffic(input int count);
      crc64rbe_pkg::byte_type data;
      bit                     first;
      bit                     last;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 7))
            0:       data = 8'h00;
            1:       data = 8'hFF;
            default: data = crc64rbe_pkg::byte_type'($urandom);
         endcase
         if ($urandom_range(0, 9) == 0) begin
            first = bit'($urandom_range(0, 1));
            last  = bit'($urandom_range(0, 1));
            if (last) begin
               msg_left = 0;
            end
         end else begin
            if (msg_left == 0) begin
               // Mostly short messages, now and then a long one.
               msg_left = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                      : $urandom_range(1, 12);
               // A message usually opens with the first mark; without it the
               // engine must still start from zero after the previous last.
               first = ($urandom_range(0, 9) != 0);
            end else begin
               first = 1'b0;
            end
            last = (msg_left == 1);
            msg_left--;
         end
         send_byte(data, first, last);
      end
   endtask

   initial begin
      crc64rbe_pkg::csr_data_type poly;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      req_tlast   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      idle_enable = 1'b1;
      msg_left    = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // One-byte messages under the reset polynomial, both data extremes.
      send_byte(8'h00, 1'b1, 1'b1);
      send_byte(8'hFF, 1'b1, 1'b1);

      // The ASCII digits one to nine as a single message.
      for (int k = 0; k < 9; k++) begin
         send_byte(crc64rbe_pkg::byte_type'(8'h31 + k), k == 0, k == 8);
      end

      // After a last byte, a message without the first mark starts from zero.
      send_byte(8'hA5, 1'b0, 1'b0);
      send_byte(8'h5A, 1'b0, 1'b1);

      // A first mark in the middle of an open message restarts it.
      send_byte(8'h80, 1'b1, 1'b0);
      send_byte(8'h01, 1'b0, 1'b0);
      send_byte(8'h7E, 1'b1, 1'b0);
      send_byte(8'hC3, 1'b0, 1'b1);

      // A write past the register map must leave the polynomial alone.
      settle_engine();
      csr_write(ADDR_UNMAPPED, '0);
      send_byte(8'h11, 1'b1, 1'b1);

      // Polynomial changed between bytes of an open message: the later byte
      // folds under the new value.
      send_byte(8'h12, 1'b1, 1'b0);
      send_byte(8'h34, 1'b0, 1'b0);
      settle_engine();
      csr_write(crc64rbe_pkg::ADDR_POLYNOMIAL, '1);
      send_byte(8'h56, 1'b0, 1'b1);

      // All-zero polynomial: the CRC degenerates to a plain shift.
      settle_engine();
      csr_write(crc64rbe_pkg::ADDR_POLYNOMIAL, '0);
      send_byte(8'hFF, 1'b1, 1'b0);
      send_byte(8'h00, 1'b0, 1'b1);

      // Random phases, each under its own polynomial. Phases may end in the
      // middle of a message, so the open message continues under the next
      // polynomial. The last phase runs without any idle cycles.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         settle_engine();
         case (phase)
            0:       poly = crc64rbe_pkg::POLY_RESET;
            2:       poly = '1;
            default: poly = {$urandom, $urandom};
         endcase
         if (phase == 3) begin
            csr_write(ADDR_UNMAPPED, {$urandom, $urandom});
         end
         csr_write(crc64rbe_pkg::ADDR_POLYNOMIAL, poly);
         if (phase == PHASE_COUNT - 1) begin
            idle_enable = 1'b0;
         end
         run_traffic(PHASE_ITEMS);
      end

      // Drain: all finished CRCs in, then a quiet tail for any stray result.
      req_tvalid <= 1'b0;
      while (crc_pending != 0) @(negedge clock);
      repeat (4 * ENGINE_SETTLE) @(negedge clock);

      if (fail_count == 0 && crc_pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
